FILE: hdl/sdk_pkg.sv
`timescale 1ns / 1ps

package sdk_pkg;

  // arctangent of 2^-i in 32 bit binary angle units
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_BAM32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // rotation cordic datapath, Q2.30 vector and 33 bit angle
  localparam int ROT_W = 33;
  typedef logic signed [ROT_W-1:0] rot_t;
  localparam rot_t CORDIC_START = 33'sd652032874;

  // yaw folding
  localparam int YAW_W = 17;
  typedef logic signed [YAW_W-1:0] yaw_t;
  localparam yaw_t YAW_QUARTER = 17'sd16384;
  localparam yaw_t YAW_HALF    = 17'sd32768;

  // products and rounding
  localparam int PROD_W = 49;
  localparam int SUM_W  = 50;
  localparam int PK_W   = 34;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  psum_t;
  typedef logic signed [PK_W-1:0]   pk_t;
  localparam psum_t RND30 = 50'sd536870912;
  localparam pk_t   RND15 = 34'sd16384;

  // wheel pair components
  localparam int PAIR_W = 19;
  typedef logic signed [PAIR_W-1:0] pair_t;

  // vectoring cordic datapath
  localparam int VEC_W = 33;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic [31:0] bam32_t;
  localparam bam32_t BAM_HALF  = 32'h8000_0000;
  localparam bam32_t BAM_ROUND = 32'h0000_8000;

  // square root
  localparam int SQ_W   = 38;
  localparam int ROOT_W = 19;
  localparam int REM_W  = 22;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [REM_W-1:0]  rem_t;

  // normalising divider
  localparam int Q_W   = 15;
  localparam int DIV_W = 33;
  typedef logic [DIV_W-1:0] div_t;
  typedef logic [Q_W-1:0]   quo_t;
  localparam quo_t  UNIT_Q14 = 15'd16384;
  localparam root_t UNIT_SPD = 19'd16384;

  localparam int LANES = 4;

endpackage

FILE: hdl/sdk_if.sv
`timescale 1ns / 1ps

interface sdk_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic signed [15:0] spin_cmd;
  logic signed [15:0] gimbal_yaw;

  modport source (output valid, move_x, move_y, spin_cmd, gimbal_yaw, input ready);
  modport sink   (input valid, move_x, move_y, spin_cmd, gimbal_yaw, output ready);
endinterface

interface sdk_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] speed_front_right;
  logic        [14:0] speed_front_left;
  logic        [14:0] speed_back_left;
  logic        [14:0] speed_back_right;
  logic signed [15:0] angle_front_right;
  logic signed [15:0] angle_front_left;
  logic signed [15:0] angle_back_left;
  logic signed [15:0] angle_back_right;
  logic               was_scaled;

  modport source (output valid, speed_front_right, speed_front_left, speed_back_left,
                  speed_back_right, angle_front_right, angle_front_left,
                  angle_back_left, angle_back_right, was_scaled, input ready);
  modport sink   (input valid, speed_front_right, speed_front_left, speed_back_left,
                  speed_back_right, angle_front_right, angle_front_left,
                  angle_back_left, angle_back_right, was_scaled, output ready);
endinterface

FILE: hdl/sdk_rot_cell.sv
`timescale 1ns / 1ps

module sdk_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  sdk_pkg::rot_t x_i,
  input  sdk_pkg::rot_t y_i,
  input  sdk_pkg::rot_t z_i,
  output sdk_pkg::rot_t x_o,
  output sdk_pkg::rot_t y_o,
  output sdk_pkg::rot_t z_o
);
  import sdk_pkg::*;

  rot_t x_r, y_r, z_r;
  rot_t x_nxt, y_nxt, z_nxt;
  rot_t atn;

  // one micro-rotation towards zero residual angle
  always_comb begin
    atn = rot_t'({1'b0, ATAN_BAM32[STEP]});
    if (z_i >= 0) begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - atn;
    end else begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + atn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

FILE: hdl/sdk_vec_cell.sv
`timescale 1ns / 1ps

module sdk_vec_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  sdk_pkg::vec_t   x_i,
  input  sdk_pkg::vec_t   y_i,
  input  sdk_pkg::bam32_t z_i,
  output sdk_pkg::vec_t   x_o,
  output sdk_pkg::vec_t   y_o,
  output sdk_pkg::bam32_t z_o
);
  import sdk_pkg::*;

  vec_t   x_r, y_r, x_nxt, y_nxt;
  bam32_t z_r, z_nxt;

  // one micro-rotation driving y towards zero, angle wraps modulo a turn
  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ATAN_BAM32[STEP];
    end else begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ATAN_BAM32[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

FILE: hdl/sdk_sqrt_cell.sv
`timescale 1ns / 1ps

module sdk_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  sdk_pkg::sq_t   rad_i,
  input  sdk_pkg::rem_t  rem_i,
  input  sdk_pkg::root_t root_i,
  output sdk_pkg::sq_t   rad_o,
  output sdk_pkg::rem_t  rem_o,
  output sdk_pkg::root_t root_o
);
  import sdk_pkg::*;

  sq_t   rad_r;
  rem_t  rem_r, rem_nxt, rem_sh, trial;
  root_t root_r, root_nxt;

  // bring in the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[2*BIT+1 -: 2]};
    trial  = rem_t'({root_i, 2'b01});
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule

FILE: hdl/sdk_div_cell.sv
`timescale 1ns / 1ps

module sdk_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  sdk_pkg::div_t  rem_i,
  input  sdk_pkg::root_t dvs_i,
  input  sdk_pkg::quo_t  quo_i,
  output sdk_pkg::div_t  rem_o,
  output sdk_pkg::root_t dvs_o,
  output sdk_pkg::quo_t  quo_o
);
  import sdk_pkg::*;

  div_t  rem_r, rem_nxt, dv;
  root_t dvs_r;
  quo_t  quo_r, quo_nxt;

  // restoring step for one quotient bit
  always_comb begin
    dv = div_t'(dvs_i) << BIT;
    if (rem_i >= dv) begin
      rem_nxt = rem_i - dv;
      quo_nxt = quo_i | (quo_t'(1) << BIT);
    end else begin
      rem_nxt = rem_i;
      quo_nxt = quo_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign quo_o = quo_r;
endmodule

FILE: hdl/swerve_drive_kinematics.sv
`timescale 1ns / 1ps
// throughput: one command per cycle while no result is held; every stage is a register cell in one chain
// the chain length is set by the sincos cordic, the 19 step square root and the
// 15 step divider; a held result freezes the whole chain until it is taken
// reset: synchronous active low, clears stage valids and sets ratio_r to 23170
module swerve_drive_kinematics #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sdk_in_if.sink      in_chan,
  sdk_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import sdk_pkg::*;

  localparam int N        = CORDIC_STAGES;
  localparam int SQRT_N   = ROOT_W;
  localparam int DIV_N    = Q_W;
  localparam int S_ABCD   = N + 2;
  localparam int S_RND    = S_ABCD + 2 + SQRT_N + 1;
  localparam int S_OUT    = S_RND + 2 + DIV_N + 1;
  localparam int LAT      = S_OUT + 1;
  localparam int ANG_DLY  = S_OUT - 1 - (S_ABCD + N + 2);

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [15:0]    ratio_r;

  // stall the whole chain only while a result is held
  assign en            = !vld_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      ratio_r <= 16'd23170;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_chan.valid};
      if (cfg_we) ratio_r <= cfg_wdata;
    end
  end

  // input stage, fold the yaw into the half plane the cordic covers
  yaw_t g17, gf;
  logic flp_nxt;
  rot_t rx_w [0:N];
  rot_t ry_w [0:N];
  rot_t rz_w [0:N];
  rot_t rx0_r, ry0_r, rz0_r;
  logic signed [15:0] mvx_r [0:N];
  logic signed [15:0] mvy_r [0:N];
  logic signed [15:0] spn_r [0:N];
  logic               flp_r [0:N];

  always_comb begin
    g17     = yaw_t'(in_chan.gimbal_yaw);
    gf      = g17;
    flp_nxt = 1'b0;
    if (g17 > YAW_QUARTER) begin
      gf      = g17 - YAW_HALF;
      flp_nxt = 1'b1;
    end else if (g17 < -YAW_QUARTER) begin
      gf      = g17 + YAW_HALF;
      flp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx0_r    <= CORDIC_START;
      ry0_r    <= '0;
      rz0_r    <= rot_t'({gf, 16'd0});
      mvx_r[0] <= in_chan.move_x;
      mvy_r[0] <= in_chan.move_y;
      spn_r[0] <= in_chan.spin_cmd;
      flp_r[0] <= flp_nxt;
      for (int i = 1; i <= N; i++) begin
        mvx_r[i] <= mvx_r[i-1];
        mvy_r[i] <= mvy_r[i-1];
        spn_r[i] <= spn_r[i-1];
        flp_r[i] <= flp_r[i-1];
      end
    end
  end

  assign rx_w[0] = rx0_r;
  assign ry_w[0] = ry0_r;
  assign rz_w[0] = rz0_r;

  // sine and cosine cell chain
  for (genvar j = 0; j < N; j++) begin : g_rot
    sdk_rot_cell #(.STEP(j)) u_cell (
      .clk (clk), .en (en),
      .x_i (rx_w[j]), .y_i (ry_w[j]), .z_i (rz_w[j]),
      .x_o (rx_w[j+1]), .y_o (ry_w[j+1]), .z_o (rz_w[j+1])
    );
  end

  // products of the frame rotation and the spin term
  rot_t  cs, sn;
  prod_t p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  pk_t   p_k_r;

  always_comb begin
    cs = flp_r[N] ? -rx_w[N] : rx_w[N];
    sn = flp_r[N] ? -ry_w[N] : ry_w[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r <= prod_t'(mvx_r[N]) * prod_t'(cs);
      p_ys_r <= prod_t'(mvy_r[N]) * prod_t'(sn);
      p_xs_r <= prod_t'(mvx_r[N]) * prod_t'(sn);
      p_yc_r <= prod_t'(mvy_r[N]) * prod_t'(cs);
      p_k_r  <= pk_t'(spn_r[N]) * signed'(pk_t'(ratio_r));
    end
  end

  // rounding to Q2.14 and the four wheel components
  psum_t nx_s, ny_s;
  pk_t   k_s;
  pair_t nx, ny, kk;
  pair_t pa_r, pb_r, pc_r, pd_r;

  always_comb begin
    nx_s = psum_t'(p_ys_r) - psum_t'(p_xc_r) + RND30;
    ny_s = -psum_t'(p_xs_r) - psum_t'(p_yc_r) + RND30;
    k_s  = p_k_r + RND15;
    nx   = nx_s[30 +: PAIR_W];
    ny   = ny_s[30 +: PAIR_W];
    kk   = k_s[15 +: PAIR_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= nx - kk;
      pb_r <= nx + kk;
      pc_r <= ny - kk;
      pd_r <= ny + kk;
    end
  end

  // lane pairs: front right, front left, back left, back right
  pair_t lp [LANES];
  pair_t lq [LANES];
  always_comb begin
    lp[0] = pb_r; lq[0] = pd_r;
    lp[1] = pb_r; lq[1] = pc_r;
    lp[2] = pa_r; lq[2] = pc_r;
    lp[3] = pa_r; lq[3] = pd_r;
  end

  // squares of the components
  sq_t sqa_r, sqb_r, sqc_r, sqd_r;
  sq_t rad_r [LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r <= sq_t'(sq_t'(pa_r) * sq_t'(pa_r));
      sqb_r <= sq_t'(sq_t'(pb_r) * sq_t'(pb_r));
      sqc_r <= sq_t'(sq_t'(pc_r) * sq_t'(pc_r));
      sqd_r <= sq_t'(sq_t'(pd_r) * sq_t'(pd_r));
      rad_r[0] <= sqb_r + sqd_r;
      rad_r[1] <= sqb_r + sqc_r;
      rad_r[2] <= sqa_r + sqc_r;
      rad_r[3] <= sqa_r + sqd_r;
    end
  end

  // square root chains, one per wheel
  sq_t   sr_rad  [LANES][0:SQRT_N];
  rem_t  sr_rem  [LANES][0:SQRT_N];
  root_t sr_root [LANES][0:SQRT_N];
  root_t spd_r   [LANES];
  root_t spm_r   [LANES];
  root_t mx_r;
  root_t mx_nxt;

  for (genvar l = 0; l < LANES; l++) begin : g_sq_lane
    assign sr_rad[l][0]  = rad_r[l];
    assign sr_rem[l][0]  = '0;
    assign sr_root[l][0] = '0;
    for (genvar j = 0; j < SQRT_N; j++) begin : g_sq
      sdk_sqrt_cell #(.BIT(SQRT_N - 1 - j)) u_cell (
        .clk (clk), .en (en),
        .rad_i (sr_rad[l][j]), .rem_i (sr_rem[l][j]), .root_i (sr_root[l][j]),
        .rad_o (sr_rad[l][j+1]), .rem_o (sr_rem[l][j+1]), .root_o (sr_root[l][j+1])
      );
    end
  end

  // round the root to nearest, then find the largest speed
  always_comb begin
    mx_nxt = spd_r[0];
    for (int l = 1; l < LANES; l++) begin
      if (spd_r[l] > mx_nxt) mx_nxt = spd_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        spd_r[l] <= sr_root[l][SQRT_N] +
                    root_t'(sr_rem[l][SQRT_N] > rem_t'(sr_root[l][SQRT_N]));
        spm_r[l] <= spd_r[l];
      end
      mx_r <= mx_nxt;
    end
  end

  // divider set-up: numerator speed * 1.0 + max / 2
  div_t dv_rem [LANES][0:DIV_N];
  root_t dv_dvs [LANES][0:DIV_N];
  quo_t dv_quo [LANES][0:DIV_N];
  div_t num_r  [LANES];
  root_t dvs0_r;
  quo_t raw_r  [LANES][0:DIV_N];
  logic scl_r  [0:DIV_N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        num_r[l]    <= (div_t'(spm_r[l]) << 14) + div_t'(mx_r >> 1);
        raw_r[l][0] <= spm_r[l][Q_W-1:0];
        for (int j = 1; j <= DIV_N; j++) raw_r[l][j] <= raw_r[l][j-1];
      end
      dvs0_r   <= mx_r;
      scl_r[0] <= mx_r > UNIT_SPD;
      for (int j = 1; j <= DIV_N; j++) scl_r[j] <= scl_r[j-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_dv_lane
    assign dv_rem[l][0] = num_r[l];
    assign dv_dvs[l][0] = dvs0_r;
    assign dv_quo[l][0] = '0;
    for (genvar j = 0; j < DIV_N; j++) begin : g_dv
      sdk_div_cell #(.BIT(DIV_N - 1 - j)) u_cell (
        .clk (clk), .en (en),
        .rem_i (dv_rem[l][j]), .dvs_i (dv_dvs[l][j]), .quo_i (dv_quo[l][j]),
        .rem_o (dv_rem[l][j+1]), .dvs_o (dv_dvs[l][j+1]), .quo_o (dv_quo[l][j+1])
      );
    end
  end

  // vectoring set-up: scale by 4096, move the left half plane over
  vec_t   vx_w  [LANES][0:N];
  vec_t   vy_w  [LANES][0:N];
  bam32_t vz_w  [LANES][0:N];
  vec_t   vx0_r [LANES];
  vec_t   vy0_r [LANES];
  bam32_t vz0_r [LANES];
  bam32_t ang_rnd [LANES];
  logic   zro_r [LANES][0:N];
  logic signed [15:0] ang_r [LANES][0:ANG_DLY];

  // round the angle to 16 bits
  always_comb begin
    for (int l = 0; l < LANES; l++) ang_rnd[l] = vz_w[l][N] + BAM_ROUND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        if (lq[l] < 0) begin
          vx0_r[l] <= -(vec_t'(lq[l]) <<< 12);
          vy0_r[l] <= -(vec_t'(lp[l]) <<< 12);
          vz0_r[l] <= BAM_HALF;
        end else begin
          vx0_r[l] <= vec_t'(lq[l]) <<< 12;
          vy0_r[l] <= vec_t'(lp[l]) <<< 12;
          vz0_r[l] <= '0;
        end
        zro_r[l][0] <= (lp[l] == '0) && (lq[l] == '0);
        for (int j = 1; j <= N; j++) zro_r[l][j] <= zro_r[l][j-1];
        // the zero vector reads as angle zero
        ang_r[l][0] <= zro_r[l][N] ? 16'sd0 : signed'(ang_rnd[l][31:16]);
        for (int j = 1; j <= ANG_DLY; j++) ang_r[l][j] <= ang_r[l][j-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_vec_lane
    assign vx_w[l][0] = vx0_r[l];
    assign vy_w[l][0] = vy0_r[l];
    assign vz_w[l][0] = vz0_r[l];
    for (genvar j = 0; j < N; j++) begin : g_vec
      sdk_vec_cell #(.STEP(j)) u_cell (
        .clk (clk), .en (en),
        .x_i (vx_w[l][j]), .y_i (vy_w[l][j]), .z_i (vz_w[l][j]),
        .x_o (vx_w[l][j+1]), .y_o (vy_w[l][j+1]), .z_o (vz_w[l][j+1])
      );
    end
  end

  // output register
  quo_t spo_r [LANES];
  logic signed [15:0] ango_r [LANES];
  logic sclo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        spo_r[l]  <= scl_r[DIV_N] ? dv_quo[l][DIV_N] : raw_r[l][DIV_N];
        ango_r[l] <= ang_r[l][ANG_DLY];
      end
      sclo_r <= scl_r[DIV_N];
    end
  end

  assign out_chan.valid             = vld_r[LAT-1];
  assign out_chan.speed_front_right = spo_r[0];
  assign out_chan.speed_front_left  = spo_r[1];
  assign out_chan.speed_back_left   = spo_r[2];
  assign out_chan.speed_back_right  = spo_r[3];
  assign out_chan.angle_front_right = ango_r[0];
  assign out_chan.angle_front_left  = ango_r[1];
  assign out_chan.angle_back_left   = ango_r[2];
  assign out_chan.angle_back_right  = ango_r[3];
  assign out_chan.was_scaled        = sclo_r;

  // speeds never exceed 1.0
  a_spd_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.speed_front_right <= UNIT_Q14) &&
      (out_chan.speed_front_left <= UNIT_Q14) && (out_chan.speed_back_left <= UNIT_Q14) &&
      (out_chan.speed_back_right <= UNIT_Q14))
    else $error("wheel speed above unit");

  // after normalising the largest wheel runs at exactly 1.0
  a_scl_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.was_scaled |->
      (out_chan.speed_front_right == UNIT_Q14) || (out_chan.speed_front_left == UNIT_Q14) ||
      (out_chan.speed_back_left == UNIT_Q14) || (out_chan.speed_back_right == UNIT_Q14))
    else $error("normalised speeds miss unit");

  // reset empties the chain
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

endmodule
